[design/utf8_string_decoder_core_macros.svh]
// Assertion macros for the UTF-8 string decoder.
`ifndef UTF8_STRING_DECODER_CORE_MACROS_SVH
`define UTF8_STRING_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define UTF8SD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utf8sd assertion failed");
`define UTF8SD_ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("utf8sd forbidden condition seen");
`else
`define UTF8SD_ASSERT(lbl, clk, rst, prop)
`define UTF8SD_ASSERT_NEVER(lbl, clk, rst, prop)
`endif

`endif

[design/utf8sd_pkg.sv]
// Types and constants shared by the UTF-8 string decoder modules.
`timescale 1ns / 1ps

package utf8sd_pkg;

   localparam int unsigned CP_WIDTH    = 21;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned CONT_BITS   = 6;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [7:0] MASK_LEAD4 = 8'hF8;
   localparam logic [7:0] MASK_LEAD3 = 8'hF0;
   localparam logic [7:0] MASK_LEAD2 = 8'hE0;
   localparam logic [7:0] MASK_CONT  = 8'hC0;
   localparam logic [7:0] CODE_LEAD4 = 8'hF0;
   localparam logic [7:0] CODE_LEAD3 = 8'hE0;
   localparam logic [7:0] CODE_LEAD2 = 8'hC0;
   localparam logic [7:0] CODE_CONT  = 8'h80;

   localparam logic [0:0] REG_MAX_CHARS = 1'b0;

   typedef enum logic [1:0] {
      ST_CHAR     = 2'd0,
      ST_TERM     = 2'd1,
      ST_INVALID  = 2'd2,
      ST_CAPACITY = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_string;
   } req_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0]    code_point;
      logic [2:0]             byte_len;
      status_type             status;
      logic [COUNT_WIDTH-1:0] char_count;
      logic                   done_res;
   } rsp_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0]    partial_value;
      logic [1:0]             bytes_left;
      logic [2:0]             char_length;
      logic [COUNT_WIDTH-1:0] count_so_far;
      logic                   finished;
   } state_type;

endpackage

[design/utf8sd_decode.sv]
// Per-byte decode logic: next decoder state and the optional result word.
`timescale 1ns / 1ps

module utf8sd_decode
   import utf8sd_pkg::*;
(
   input  state_type              state,
   input  req_type                req,
   input  logic [COUNT_WIDTH-1:0] max_chars,
   output state_type              state_next,
   output logic                   has_result,
   output rsp_type                rsp
);

   state_type              cur;
   logic [7:0]             b;
   logic                   limited;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   finish;
   logic [CP_WIDTH-1:0]    fin_cp;
   logic [2:0]             fin_len;

   assign b       = req.in_byte;
   assign limited = (max_chars != '0);

   always_comb begin
      cur = state;
      if (req.new_string) begin
         cur = '0;
      end
      state_next     = cur;
      has_result     = 1'b0;
      rsp.code_point = '0;
      rsp.byte_len   = '0;
      rsp.status     = ST_CHAR;
      rsp.char_count = cur.count_so_far;
      rsp.done_res   = 1'b0;
      finish         = 1'b0;
      fin_cp         = '0;
      fin_len        = '0;
      count_inc      = (cur.count_so_far != COUNT_MAX) ? cur.count_so_far + 1'b1
                                                       : cur.count_so_far;
      if (!cur.finished) begin
         if (cur.bytes_left == 2'd0) begin
            if (limited && (cur.count_so_far >= max_chars)) begin
               has_result = 1'b1;
               rsp.status = ST_CAPACITY;
            end else if (b == 8'h00) begin
               has_result = 1'b1;
               rsp.status = ST_TERM;
            end else if (!b[7]) begin
               finish  = 1'b1;
               fin_cp  = CP_WIDTH'(b);
               fin_len = 3'd1;
            end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
               state_next.partial_value = CP_WIDTH'(b[4:0]);
               state_next.char_length   = 3'd2;
               state_next.bytes_left    = 2'd1;
            end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
               state_next.partial_value = CP_WIDTH'(b[3:0]);
               state_next.char_length   = 3'd3;
               state_next.bytes_left    = 2'd2;
            end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
               state_next.partial_value = CP_WIDTH'(b[2:0]);
               state_next.char_length   = 3'd4;
               state_next.bytes_left    = 2'd3;
            end else begin
               has_result = 1'b1;
               rsp.status = ST_INVALID;
            end
         end else if ((b & MASK_CONT) != CODE_CONT) begin
            has_result               = 1'b1;
            rsp.status               = ST_INVALID;
            state_next.partial_value = '0;
            state_next.char_length   = '0;
         end else begin
            state_next.partial_value =
               {cur.partial_value[CP_WIDTH-CONT_BITS-1:0], b[CONT_BITS-1:0]};
            state_next.bytes_left    = cur.bytes_left - 2'd1;
            if (cur.bytes_left == 2'd1) begin
               finish  = 1'b1;
               fin_cp  = {cur.partial_value[CP_WIDTH-CONT_BITS-1:0], b[CONT_BITS-1:0]};
               fin_len = cur.char_length;
            end
         end

         if (finish) begin
            has_result               = 1'b1;
            rsp.code_point           = fin_cp;
            rsp.byte_len             = fin_len;
            rsp.char_count           = count_inc;
            rsp.status               = (limited && (count_inc >= max_chars)) ? ST_CAPACITY
                                                                             : ST_CHAR;
            state_next.count_so_far  = count_inc;
            state_next.partial_value = '0;
            state_next.char_length   = '0;
         end

         if (has_result && (rsp.status != ST_CHAR)) begin
            rsp.done_res          = 1'b1;
            state_next.finished   = 1'b1;
            state_next.bytes_left = '0;
         end
      end
   end

endmodule

[design/utf8_string_decoder_core.sv]
// Top level of the UTF-8 string decoder: handshakes, state, result register, register port.
`timescale 1ns / 1ps
`include "utf8_string_decoder_core_macros.svh"

// The decoder takes one byte of a UTF-8 string per cycle and returns, in the cycle after the
// byte is taken, at most one result word: a finished code point with its length and the
// running character count, or the end of the string (terminator, invalid sequence or
// capacity reached). Bytes that only start or continue a character give no word. A byte
// can be taken in every cycle; req_stall rises only while a result word waits in the
// output register and rsp_stall holds it there. Set new_string on the first byte of each
// string. Write max_chars at address 0 only while no byte is in flight.
module utf8_string_decoder_core
   import utf8sd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [COUNT_WIDTH-1:0] max_chars_ff, max_chars_in;

   state_type step_state;
   logic      step_has_result;
   rsp_type   step_rsp;
   logic      req_accept;
   logic      csr_write;

   utf8sd_decode u_decode (
      .state      (state_ff),
      .req        (req_data),
      .max_chars  (max_chars_ff),
      .state_next (step_state),
      .has_result (step_has_result),
      .rsp        (step_rsp)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_CHARS) ? 32'(max_chars_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      max_chars_in = max_chars_ff;
      if (req_accept) begin
         state_in     = step_state;
         rsp_valid_in = step_has_result;
         rsp_data_in  = step_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_write && (csr_paddr[2] == REG_MAX_CHARS)) begin
         max_chars_in = csr_pwdata[COUNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_chars_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_chars_ff <= max_chars_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `UTF8SD_ASSERT_NEVER(a_finished_no_partial, clock, reset, state_ff.finished && (state_ff.bytes_left != 2'd0))
   `UTF8SD_ASSERT(a_done_ends_string, clock, reset, (req_accept && step_has_result && step_rsp.done_res) |=> state_ff.finished)
   `UTF8SD_ASSERT(a_char_word_shape, clock, reset, (rsp_valid && (rsp_data.status == ST_CHAR)) |-> ((rsp_data.byte_len != 3'd0) && !rsp_data.done_res))

endmodule
